FILE: hdl/hmbd_pkg.sv
// Shared constants and controller/datapath types for the memory bus decoder.
package hmbd_pkg;

    localparam int BIOS_BYTES  = 16384;
    localparam int IO_BYTES    = 1024;
    localparam int ROM_BYTES   = 1048576;
    localparam int EWRAM_BYTES = 262144;
    localparam int IWRAM_BYTES = 32768;
    localparam int SMALL_BYTES = 1024;
    localparam int VRAM_BYTES  = 98304;

    localparam int BIOS_WORDS  = BIOS_BYTES / 4;
    localparam int IO_WORDS    = IO_BYTES / 4;
    localparam int ROM_WORDS   = ROM_BYTES / 4;
    localparam int EWRAM_WORDS = EWRAM_BYTES / 4;
    localparam int IWRAM_WORDS = IWRAM_BYTES / 4;
    localparam int SMALL_WORDS = SMALL_BYTES / 4;
    localparam int VRAM_WORDS  = VRAM_BYTES / 4;

    // clearing sweep covers the deepest zero-reset store
    localparam int CLR_WORDS = EWRAM_WORDS;
    localparam int CLR_W     = $clog2(CLR_WORDS);

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_PRELOAD = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_RSVD = 2'd3;

    localparam logic [3:0] RG_BIOS  = 4'h0;
    localparam logic [3:0] RG_EWRAM = 4'h2;
    localparam logic [3:0] RG_IWRAM = 4'h3;
    localparam logic [3:0] RG_IO    = 4'h4;
    localparam logic [3:0] RG_PAL   = 4'h5;
    localparam logic [3:0] RG_VRAM  = 4'h6;
    localparam logic [3:0] RG_OAM   = 4'h7;
    localparam logic [3:0] RG_ROM_LO = 4'h8;
    localparam logic [3:0] RG_ROM_HI = 4'hD;
    localparam logic [3:0] RG_FLASH_LO = 4'hE;

    localparam logic [3:0] MEM_NONE  = 4'd0;
    localparam logic [3:0] MEM_BIOS  = 4'd1;
    localparam logic [3:0] MEM_EWRAM = 4'd2;
    localparam logic [3:0] MEM_IWRAM = 4'd3;
    localparam logic [3:0] MEM_IO    = 4'd4;
    localparam logic [3:0] MEM_PAL   = 4'd5;
    localparam logic [3:0] MEM_VRAM  = 4'd6;
    localparam logic [3:0] MEM_OAM   = 4'd7;
    localparam logic [3:0] MEM_ROM   = 4'd8;

    localparam logic [1:0] CFG_ROM_BYTES = 2'd0;

    typedef struct packed {
        logic clr;
        logic load;
        logic mem_go;
        logic fmt;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_sts;

endpackage

FILE: hdl/hmbd_if.sv
// Request and response channel interfaces.
interface hmbd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_data;
    modport source (output valid, op, access_size, address, write_data, input ready);
    modport sink (input valid, op, access_size, address, write_data, output ready);
endinterface

interface hmbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        write_dropped;
    logic        flash_request;
    logic        flash_is_write;
    logic [15:0] flash_offset;
    logic [7:0]  flash_byte;
    modport source (output valid, read_data, write_dropped, flash_request, flash_is_write,
                    flash_offset, flash_byte, input ready);
    modport sink (input valid, read_data, write_dropped, flash_request, flash_is_write,
                  flash_offset, flash_byte, output ready);
endinterface

FILE: hdl/handheld_memory_bus_decoder.sv
// Top level: memory bus decoder with APB config port.
// A bus access is accepted only while the block is idle; its response beat is offered once
// the memory access, the registered read data and its formatting into the output
// registers are through, and held until taken. The next request is accepted no earlier
// than the cycle after the response is taken, so accesses do not overlap; the region
// memories' registered read port sets this state sequence. After reset, a clearing sweep over
// 65536 word addresses zeroes the RAMs (one word of every store per cycle) before the first
// request beat is accepted; ROM contents are undefined until preloaded.
module handheld_memory_bus_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hmbd_req_if.sink    i_req,
    hmbd_rsp_if.source  o_rsp,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import hmbd_pkg::*;

    logic [20:0] r_rom_bytes;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bytes <= '0;
        end else if (i_psel && i_penable && i_pwrite && i_paddr == {CFG_ROM_BYTES, 1'b0}) begin
            r_rom_bytes <= i_pwdata[20:0];
        end
    end
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == {CFG_ROM_BYTES, 1'b0}) ? {11'd0, r_rom_bytes} : 32'd0;

    hmbd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .i_sts(sts), .o_cmd(cmd));

    hmbd_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_rom_bytes(r_rom_bytes),
        .i_op(i_req.op), .i_size(i_req.access_size),
        .i_addr(i_req.address), .i_wdata(i_req.write_data),
        .o_read_data(o_rsp.read_data), .o_write_dropped(o_rsp.write_dropped),
        .o_flash_request(o_rsp.flash_request), .o_flash_is_write(o_rsp.flash_is_write),
        .o_flash_offset(o_rsp.flash_offset), .o_flash_byte(o_rsp.flash_byte));
endmodule

FILE: hdl/hmbd_ram.sv
// Word-wide byte-lane RAM with registered read.
module hmbd_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [3:0]    i_be,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < 4; b++) begin
                if (i_be[b]) begin
                    r_mem[i_addr][8*b +: 8] <= i_wdata[8*b +: 8];
                end
            end
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: hdl/hmbd_ctrl.sv
// Controller: clearing sweep, accept, memory access, format and output beat.
module hmbd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  hmbd_pkg::t_sts i_sts,
    output hmbd_pkg::t_cmd o_cmd
);
    import hmbd_pkg::*;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MEM  = 3'd2;
    localparam logic [2:0] ST_FMT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:  if (i_sts.clr_done) n_state = ST_IDLE;
            ST_IDLE: if (i_in_valid) n_state = ST_MEM;
            ST_MEM:  n_state = ST_FMT;
            ST_FMT:  n_state = ST_OUT;
            ST_OUT:  if (i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_cmd.clr    = (r_state == ST_CLR);
    assign o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.mem_go = (r_state == ST_MEM);
    assign o_cmd.fmt    = (r_state == ST_FMT);
endmodule

FILE: hdl/hmbd_dp.sv
// Datapath: address decode, region memories and read formatting.
module hmbd_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hmbd_pkg::t_cmd i_cmd,
    output hmbd_pkg::t_sts o_sts,
    input  logic [20:0]    i_rom_bytes,
    input  logic [1:0]     i_op,
    input  logic [1:0]     i_size,
    input  logic [31:0]    i_addr,
    input  logic [31:0]    i_wdata,
    output logic [31:0]    o_read_data,
    output logic           o_write_dropped,
    output logic           o_flash_request,
    output logic           o_flash_is_write,
    output logic [15:0]    o_flash_offset,
    output logic [7:0]     o_flash_byte
);
    import hmbd_pkg::*;

    // decode of the incoming beat
    logic [1:0]  sz;
    logic [31:0] a;
    logic [3:0]  rg;
    logic [1:0]  nm1;
    logic [24:0] last24;
    logic [25:0] last25;
    logic [20:0] rom_lim;
    logic        bios_ok, io_ok, rom_rd_ok, rom_pl_ok, is_rom, is_flash;
    logic [3:0]  be_norm, be_half;
    logic [31:0] wd;
    logic [3:0]  tgt;
    logic        we, drop, freq, fwr;

    always_comb begin
        sz = (i_op == OP_PRELOAD || i_size == SZ_RSVD) ? SZ_WORD : i_size;
        a  = i_addr;
        unique case (sz)
            SZ_BYTE: nm1 = 2'd0;
            SZ_HALF: nm1 = 2'd1;
            default: nm1 = 2'd3;
        endcase
        a[1:0]  = i_addr[1:0] & ~nm1;
        rg      = a[27:24];
        last24  = {1'b0, a[23:0]} + 25'(nm1);
        last25  = {1'b0, a[24:0]} + 26'(nm1);
        rom_lim = (i_rom_bytes < 21'(ROM_BYTES)) ? i_rom_bytes : 21'(ROM_BYTES);
        bios_ok   = last24 < 25'(BIOS_BYTES);
        io_ok     = last24 < 25'(IO_BYTES);
        rom_rd_ok = last25 < 26'(rom_lim);
        rom_pl_ok = last25 < 26'(ROM_BYTES);
        is_rom    = (rg >= RG_ROM_LO) && (rg <= RG_ROM_HI);
        is_flash  = (rg >= RG_FLASH_LO);
        be_half   = a[1] ? 4'b1100 : 4'b0011;
        unique case (sz)
            SZ_BYTE: begin
                be_norm = 4'b0001 << a[1:0];
                wd      = {4{i_wdata[7:0]}};
            end
            SZ_HALF: begin
                be_norm = be_half;
                wd      = {2{i_wdata[15:0]}};
            end
            default: begin
                be_norm = 4'b1111;
                wd      = i_wdata;
            end
        endcase

        tgt  = MEM_NONE;
        we   = 1'b0;
        drop = 1'b0;
        freq = 1'b0;
        fwr  = 1'b0;
        unique case (i_op)
            OP_READ: begin
                priority if (rg == RG_BIOS) begin
                    if (bios_ok) tgt = MEM_BIOS;
                end else if (rg == RG_EWRAM) begin
                    tgt = MEM_EWRAM;
                end else if (rg == RG_IWRAM) begin
                    tgt = MEM_IWRAM;
                end else if (rg == RG_IO) begin
                    if (io_ok) tgt = MEM_IO;
                end else if (rg == RG_PAL) begin
                    tgt = MEM_PAL;
                end else if (rg == RG_VRAM) begin
                    tgt = MEM_VRAM;
                end else if (rg == RG_OAM) begin
                    tgt = MEM_OAM;
                end else if (is_rom) begin
                    if (rom_rd_ok) tgt = MEM_ROM;
                end else if (is_flash) begin
                    freq = 1'b1;
                end else begin
                    tgt = MEM_NONE;
                end
            end
            OP_WRITE: begin
                we = 1'b1;
                priority if (rg == RG_EWRAM) begin
                    tgt = MEM_EWRAM;
                end else if (rg == RG_IWRAM) begin
                    tgt = MEM_IWRAM;
                end else if (rg == RG_IO) begin
                    if (io_ok) tgt = MEM_IO;
                    else drop = 1'b1;
                end else if (rg == RG_PAL) begin
                    tgt = MEM_PAL;
                end else if (rg == RG_VRAM) begin
                    tgt = MEM_VRAM;
                end else if (rg == RG_OAM) begin
                    if (sz == SZ_BYTE) drop = 1'b1;
                    else tgt = MEM_OAM;
                end else if (is_flash) begin
                    freq = 1'b1;
                    fwr  = 1'b1;
                end else begin
                    drop = 1'b1;
                end
            end
            OP_PRELOAD: begin
                we = 1'b1;
                priority if (rg == RG_BIOS) begin
                    if (bios_ok) tgt = MEM_BIOS;
                    else drop = 1'b1;
                end else if (is_rom) begin
                    if (rom_pl_ok) tgt = MEM_ROM;
                    else drop = 1'b1;
                end else begin
                    drop = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // captured beat
    logic [31:0] r_a;
    logic [3:0]  r_tgt, r_be;
    logic        r_we, r_drop, r_freq, r_fwr;
    logic [31:0] r_wd;
    logic [1:0]  r_sz;
    logic [16:0] r_vidx;
    logic [CLR_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= a;
            r_tgt  <= tgt;
            r_we   <= we;
            r_be   <= ((tgt == MEM_PAL || tgt == MEM_VRAM) && sz == SZ_BYTE) ? be_half
                                                                            : be_norm;
            r_wd   <= wd;
            r_sz   <= sz;
            r_drop <= drop;
            r_freq <= freq;
            r_fwr  <= fwr;
            // top 32 KiB of the VRAM window folds onto the upper bank
            r_vidx <= (a[16:0] >= 17'h18000) ? (a[16:0] - 17'h08000) : a[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end
    assign o_sts.clr_done = i_cmd.clr && (r_cnt == CLR_W'(CLR_WORDS - 1));

    // memory control
    logic        wr_go;
    logic [3:0]  m_be;
    logic [31:0] m_wd;
    assign wr_go = i_cmd.mem_go && r_we;
    assign m_be  = i_cmd.clr ? 4'b1111 : r_be;
    assign m_wd  = i_cmd.clr ? 32'd0 : r_wd;

    logic [31:0] rd_bios, rd_ewram, rd_iwram, rd_io, rd_pal, rd_vram, rd_oam, rd_rom;
    logic        vram_clr_ok;
    assign vram_clr_ok = r_cnt < CLR_W'(VRAM_WORDS);

    hmbd_ram #(.DEPTH(BIOS_WORDS)) u_bios (
        .i_clk(i_clk), .i_we(i_cmd.clr || (wr_go && r_tgt == MEM_BIOS)), .i_be(m_be),
        .i_addr(i_cmd.clr ? r_cnt[$clog2(BIOS_WORDS)-1:0] : r_a[$clog2(BIOS_BYTES)-1:2]),
        .i_wdata(m_wd), .o_rdata(rd_bios));
    hmbd_ram #(.DEPTH(EWRAM_WORDS)) u_ewram (
        .i_clk(i_clk), .i_we(i_cmd.clr || (wr_go && r_tgt == MEM_EWRAM)), .i_be(m_be),
        .i_addr(i_cmd.clr ? r_cnt[$clog2(EWRAM_WORDS)-1:0] : r_a[$clog2(EWRAM_BYTES)-1:2]),
        .i_wdata(m_wd), .o_rdata(rd_ewram));
    hmbd_ram #(.DEPTH(IWRAM_WORDS)) u_iwram (
        .i_clk(i_clk), .i_we(i_cmd.clr || (wr_go && r_tgt == MEM_IWRAM)), .i_be(m_be),
        .i_addr(i_cmd.clr ? r_cnt[$clog2(IWRAM_WORDS)-1:0] : r_a[$clog2(IWRAM_BYTES)-1:2]),
        .i_wdata(m_wd), .o_rdata(rd_iwram));
    hmbd_ram #(.DEPTH(IO_WORDS)) u_io (
        .i_clk(i_clk), .i_we(i_cmd.clr || (wr_go && r_tgt == MEM_IO)), .i_be(m_be),
        .i_addr(i_cmd.clr ? r_cnt[$clog2(IO_WORDS)-1:0] : r_a[$clog2(IO_BYTES)-1:2]),
        .i_wdata(m_wd), .o_rdata(rd_io));
    hmbd_ram #(.DEPTH(SMALL_WORDS)) u_pal (
        .i_clk(i_clk), .i_we(i_cmd.clr || (wr_go && r_tgt == MEM_PAL)), .i_be(m_be),
        .i_addr(i_cmd.clr ? r_cnt[$clog2(SMALL_WORDS)-1:0] : r_a[$clog2(SMALL_BYTES)-1:2]),
        .i_wdata(m_wd), .o_rdata(rd_pal));
    hmbd_ram #(.DEPTH(VRAM_WORDS)) u_vram (
        .i_clk(i_clk), .i_we((i_cmd.clr && vram_clr_ok) || (wr_go && r_tgt == MEM_VRAM)),
        .i_be(m_be),
        .i_addr(i_cmd.clr ? r_cnt[$clog2(VRAM_WORDS)-1:0] : r_vidx[16:2]),
        .i_wdata(m_wd), .o_rdata(rd_vram));
    hmbd_ram #(.DEPTH(SMALL_WORDS)) u_oam (
        .i_clk(i_clk), .i_we(i_cmd.clr || (wr_go && r_tgt == MEM_OAM)), .i_be(m_be),
        .i_addr(i_cmd.clr ? r_cnt[$clog2(SMALL_WORDS)-1:0] : r_a[$clog2(SMALL_BYTES)-1:2]),
        .i_wdata(m_wd), .o_rdata(rd_oam));
    hmbd_ram #(.DEPTH(ROM_WORDS)) u_rom (
        .i_clk(i_clk), .i_we(wr_go && r_tgt == MEM_ROM), .i_be(r_be),
        .i_addr(r_a[$clog2(ROM_BYTES)-1:2]), .i_wdata(r_wd), .o_rdata(rd_rom));

    // read formatting
    logic [31:0] word, shifted, rd;
    always_comb begin
        unique case (r_tgt)
            MEM_BIOS:  word = rd_bios;
            MEM_EWRAM: word = rd_ewram;
            MEM_IWRAM: word = rd_iwram;
            MEM_IO:    word = rd_io;
            MEM_PAL:   word = rd_pal;
            MEM_VRAM:  word = rd_vram;
            MEM_OAM:   word = rd_oam;
            MEM_ROM:   word = rd_rom;
            default:   word = 32'd0;
        endcase
        shifted = word >> {r_a[1:0], 3'b000};
        unique case (r_sz)
            SZ_BYTE: rd = {24'd0, shifted[7:0]};
            SZ_HALF: rd = {16'd0, shifted[15:0]};
            default: rd = shifted;
        endcase
        if (r_we) rd = 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fmt) begin
            o_read_data      <= rd;
            o_write_dropped  <= r_drop;
            o_flash_request  <= r_freq;
            o_flash_is_write <= r_fwr;
            o_flash_offset   <= r_freq ? r_a[15:0] : 16'd0;
            o_flash_byte     <= r_fwr ? r_wd[7:0] : 8'd0;
        end
    end
endmodule
